@@ design/pde_pkg.sv @@
// Package for the platform device enumerator.
// Holds the table record type, request and status codes and the register map.
// No dependencies.
`default_nettype none

package pde_pkg;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] base;
    logic [31:0] size;
    logic [7:0]  irq;
    logic [7:0]  irq_span;
    logic [7:0]  name_len;
  } entry_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_OFFSET = 2'd1;
  localparam logic [1:0] ST_BAD_VALUE  = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  localparam logic [11:0] REG_OP        = 12'h000;
  localparam logic [11:0] REG_NAME_ADDR = 12'h004;
  localparam logic [11:0] REG_NAME_LEN  = 12'h008;
  localparam logic [11:0] REG_ID        = 12'h00c;
  localparam logic [11:0] REG_BASE      = 12'h010;
  localparam logic [11:0] REG_SIZE      = 12'h014;
  localparam logic [11:0] REG_IRQ       = 12'h018;
  localparam logic [11:0] REG_IRQ_COUNT = 12'h01c;

  localparam logic [31:0] RD_ADD_DEVICE = 32'd8;
  localparam logic [31:0] RD_DONE       = 32'd0;

  localparam logic CFG_FIRST_BASE = 1'b0;
  localparam logic CFG_FIRST_IRQ  = 1'b1;

endpackage

`default_nettype wire

@@ design/pde_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the device table of the platform device enumerator; no dependencies.
`default_nettype none

module pde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/platform_device_enumerator_top.sv @@
// Top level of the platform device enumerator: sequencer, allocators and table.
// Depends on pde_pkg and on pde_ram for the device table.
//
// A request is taken when the block is idle and its result is handed on
// through an output register, so a new request may be taken while a result
// still waits there. An add, a field read or a register write steps through
// S_EXEC and S_EMIT, where it waits until the output register is free. A read
// of the op register also passes through S_SKIP, which steps over every
// already reported entry of the walk, testing one reported flag per cycle.
// The device records live in a RAM whose registered read port always
// follows the walk cursor.
`default_nettype none

module platform_device_enumerator_top
  import pde_pkg::*;
#(
  parameter int MAX_DEVICES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [11:0] offset,
  input  wire logic [31:0] wdata,
  input  wire logic [31:0] new_id,
  input  wire logic [31:0] new_base,
  input  wire logic [31:0] new_size,
  input  wire logic [7:0]  new_irq,
  input  wire logic [7:0]  new_irq_count,
  input  wire logic [7:0]  new_name_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      rdata,
  output logic             irq_level,
  output logic [1:0]       status,
  output logic [31:0]      assigned_base,
  output logic [7:0]       assigned_irq
);

  localparam int IDXW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNTW = $clog2(MAX_DEVICES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;

  logic [31:0] first_base;
  logic [7:0]  first_irq;
  logic [31:0] next_base;
  logic [7:0]  next_irq;

  logic [CNTW-1:0]        count;
  logic [IDXW-1:0]        cursor;
  logic                   cursor_valid;
  logic [MAX_DEVICES-1:0] reported;
  logic                   irq_line;

  op_t         req_op;
  logic [11:0] req_offset;
  logic [31:0] req_wdata;
  logic [31:0] req_id;
  logic [31:0] req_base;
  logic [31:0] req_size;
  logic [7:0]  req_irq;
  logic [7:0]  req_irq_span;
  logic [7:0]  req_name_len;

  logic [31:0] res_rdata;
  logic [1:0]  res_status;
  logic [31:0] res_abase;
  logic [7:0]  res_airq;

  entry_t          ram_d;
  entry_t          ram_q;
  logic            ram_we;
  logic            full;
  logic            auto_base;
  logic            auto_irq;
  logic [31:0]     add_base;
  logic [7:0]      add_irq;
  logic [CNTW-1:0] cursor_inc;
  logic            cursor_has_next;
  logic            emit_go;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    full            = (count == CNTW'(MAX_DEVICES));
    auto_base       = (req_base == 32'd0);
    auto_irq        = (req_irq == 8'd0) && (req_irq_span != 8'd0);
    add_base        = auto_base ? next_base : req_base;
    add_irq         = auto_irq ? next_irq : req_irq;
    cursor_inc      = CNTW'(cursor) + 1'b1;
    cursor_has_next = (cursor_inc < count);
    ram_we          = (state == S_EXEC) && (req_op == OP_ADD) && !full;
    emit_go         = (state == S_EMIT) && (!out_valid || out_ready);
    ram_d.id        = req_id;
    ram_d.base      = add_base;
    ram_d.size      = req_size;
    ram_d.irq       = add_irq;
    ram_d.irq_span  = req_irq_span;
    ram_d.name_len  = req_name_len;
  end

  pde_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_DEVICES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDXW-1:0]),
    .wdata(ram_d),
    .raddr(cursor),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_base   <= '0;
      first_irq    <= '0;
      next_base    <= '0;
      next_irq     <= '0;
      count        <= '0;
      cursor       <= '0;
      cursor_valid <= 1'b0;
      reported     <= '0;
      irq_line     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_op        <= op_t'(op);
            req_offset    <= offset;
            req_wdata     <= wdata;
            req_id        <= new_id;
            req_base      <= new_base;
            req_size      <= new_size;
            req_irq       <= new_irq;
            req_irq_span  <= new_irq_count;
            req_name_len  <= new_name_len;
            res_rdata     <= '0;
            res_status    <= ST_OK;
            res_abase     <= '0;
            res_airq      <= '0;
            state         <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= ((req_op == OP_READ) && (req_offset == REG_OP)) ? S_SKIP : S_EMIT;
          unique case (req_op)
            OP_ADD: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                count                      <= count + 1'b1;
                reported[count[IDXW-1:0]]  <= 1'b0;
                res_abase                  <= add_base;
                res_airq                   <= add_irq;
                if (auto_base) begin
                  next_base <= next_base + req_size;
                end
                if (auto_irq) begin
                  next_irq <= next_irq + req_irq_span;
                end
              end
            end
            OP_READ: begin
              unique case (req_offset)
                REG_OP: begin
                  // Mark the current device reported and step on or end the walk, or else restart it.
                  if (cursor_valid) begin
                    reported[cursor] <= 1'b1;
                    if (cursor_has_next) begin
                      cursor <= cursor_inc[IDXW-1:0];
                    end else begin
                      cursor_valid <= 1'b0;
                    end
                  end else if (count != '0) begin
                    cursor       <= '0;
                    cursor_valid <= 1'b1;
                  end
                end
                REG_NAME_LEN:  res_rdata <= cursor_valid ? 32'(ram_q.name_len) : '0;
                REG_ID:        res_rdata <= cursor_valid ? ram_q.id : '0;
                REG_BASE:      res_rdata <= cursor_valid ? ram_q.base : '0;
                REG_SIZE:      res_rdata <= cursor_valid ? ram_q.size : '0;
                REG_IRQ:       res_rdata <= cursor_valid ? 32'(ram_q.irq) : '0;
                REG_IRQ_COUNT: res_rdata <= cursor_valid ? 32'(ram_q.irq_span) : '0;
                default:       res_status <= ST_BAD_OFFSET;
              endcase
            end
            OP_WRITE: begin
              if (req_offset == REG_OP) begin
                if (req_wdata == 32'd0) begin
                  reported     <= '0;
                  cursor       <= '0;
                  cursor_valid <= 1'b0;
                  irq_line     <= (count != '0);
                end else begin
                  res_status <= ST_BAD_VALUE;
                end
              end else if (req_offset != REG_NAME_ADDR) begin
                res_status <= ST_BAD_OFFSET;
              end
            end
            default: res_status <= ST_BAD_VALUE;
          endcase
        end

        S_SKIP: begin
          if (cursor_valid && reported[cursor]) begin
            if (cursor_has_next) begin
              cursor <= cursor_inc[IDXW-1:0];
            end else begin
              cursor_valid <= 1'b0;
            end
          end else begin
            res_rdata <= cursor_valid ? RD_ADD_DEVICE : RD_DONE;
            if (!cursor_valid) begin
              irq_line <= 1'b0;
            end
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_go) begin
            rdata         <= res_rdata;
            irq_level     <= irq_line;
            status        <= res_status;
            assigned_base <= res_abase;
            assigned_irq  <= res_airq;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // Both allocators restart from the register values on any register write.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIRST_BASE: begin
            first_base <= cfg_wdata;
            next_base  <= cfg_wdata;
            next_irq   <= first_irq;
          end
          CFG_FIRST_IRQ: begin
            first_irq <= cfg_wdata[7:0];
            next_irq  <= cfg_wdata[7:0];
            next_base <= first_base;
          end
          default: ;
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_DEVICES))
    else $error("device count beyond table depth");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (rst)
    cursor_valid |-> (CNTW'(cursor) < count))
    else $error("cursor points past the last device");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> full)
    else $error("table full reported while space remains");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted request not executed");

endmodule

`default_nettype wire
